[sv/indexed_list_engine_macros.svh]
// Assertion macros used by the checker file of the indexed list engine.
`ifndef INDEXED_LIST_ENGINE_MACROS_SVH
`define INDEXED_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define ILE_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define ILE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/ile_pkg.sv]
// Package with the command, status and state codes of the indexed list engine.
package ile_pkg;

    localparam int VALUE_W  = 32;
    localparam int POS_W    = 8;
    localparam int CMD_W    = 3;
    localparam int STATUS_W = 2;
    localparam int ECOUNT_W = 7;

    // Stream beat widths, padded to whole bytes.
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 48;

    typedef enum logic [CMD_W-1:0] {
        CMD_READ = 3'd0,
        CMD_HEAD = 3'd1,
        CMD_TAIL = 3'd2,
        CMD_AT   = 3'd3,
        CMD_DEL  = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_RDWAIT = 4'b0010,
        ST_SHIFT  = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

endpackage

[sv/indexed_list_engine.sv]
// Indexed list engine: one command beat in, one result beat out.
// A refused command goes straight to the result load; an in-range read first waits for the
// memory read data; an insert or delete reads each entry that moves and writes it back one
// slot over, then does the final write or shrink, then the result load.
// Commands are taken one at a time: the next is accepted only after the result load, which waits on a result stall.
// Reset (rst_n low, asynchronous) empties the list; the memory contents are not cleared.
module indexed_list_engine #(
    parameter int LIST_DEPTH = 64
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // command [2:0], position [10:3], value [42:11], zero padding [47:43]
    input  logic [ile_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // read_value [31:0], status [33:32], entry_count [40:34], zero padding [47:41]
    output logic [ile_pkg::M_TDATA_W-1:0] m_tdata
);
    import ile_pkg::*;

    // Address width of the list memory and width of the entry count.
    localparam int AW   = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
    localparam int CW   = $clog2(LIST_DEPTH + 1);
    // Compare width: holds any position or count plus one without wrapping.
    localparam int CMPW = ((CW > POS_W) ? CW : POS_W) + 1;

    // The list itself: one synchronous memory, one write and one read port.
    logic [VALUE_W-1:0] mem_array [LIST_DEPTH];
    logic [VALUE_W-1:0] mem_q;
    logic               mem_we;
    logic [AW-1:0]      mem_waddr;
    logic [VALUE_W-1:0] mem_wdata;
    logic               mem_re;
    logic [AW-1:0]      mem_raddr;

    // Control state.
    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic          issue_reg, issue_next;   // more shift reads to launch
    logic          pend_reg, pend_next;     // read data in mem_q waits to be written back
    logic          out_valid_reg, out_valid_next;

    // Shift sequencer and result payload.
    logic [AW-1:0]       ptr_reg, ptr_next;    // next address to read
    logic [AW-1:0]       last_reg, last_next;  // last address to read
    logic [AW-1:0]       src_reg, src_next;    // address whose data sits in mem_q
    logic [AW-1:0]       ins_reg, ins_next;    // insertion point
    logic                del_reg, del_next;    // shift direction: down for a delete
    logic [VALUE_W-1:0]  val_reg, val_next;
    logic [VALUE_W-1:0]  res_value_reg, res_value_next;
    status_t             res_status_reg, res_status_next;
    logic [VALUE_W-1:0]  out_value_reg, out_value_next;
    status_t             out_status_reg, out_status_next;
    logic [ECOUNT_W-1:0] out_count_reg, out_count_next;

    // Unpacked command beat.
    logic [CMD_W-1:0]   in_cmd;
    logic [POS_W-1:0]   in_pos;
    logic [VALUE_W-1:0] in_val;
    logic [CMPW-1:0]    pos_ext;
    logic [CMPW-1:0]    cnt_ext;
    logic [CMPW-1:0]    ins_ext;
    logic [CMPW-1:0]    pos_inc;
    logic [CW-1:0]      cnt_dec;
    logic               list_full;
    logic               accept;
    logic               out_free;

    assign in_cmd  = s_tdata[CMD_W-1:0];
    assign in_pos  = s_tdata[CMD_W+POS_W-1:CMD_W];
    assign in_val  = s_tdata[CMD_W+POS_W+VALUE_W-1:CMD_W+POS_W];

    assign pos_ext   = CMPW'(in_pos);
    assign cnt_ext   = CMPW'(count_reg);
    assign pos_inc   = pos_ext + CMPW'(1);
    assign cnt_dec   = count_reg - CW'(1);
    assign list_full = (count_reg == CW'(LIST_DEPTH));

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // Insertion point of the three insert commands.
    always_comb
    begin
        case (in_cmd)
            CMD_HEAD: ins_ext = '0;
            CMD_TAIL: ins_ext = cnt_ext;
            default:  ins_ext = pos_ext;
        endcase
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        issue_next      = issue_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        ptr_next        = ptr_reg;
        last_next       = last_reg;
        src_next        = src_reg;
        ins_next        = ins_reg;
        del_next        = del_reg;
        val_next        = val_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        out_value_next  = out_value_reg;
        out_status_next = out_status_reg;
        out_count_next  = out_count_reg;
        mem_we          = 1'b0;
        mem_waddr       = ins_reg;
        mem_wdata       = val_reg;
        mem_re          = 1'b0;
        mem_raddr       = ptr_reg;

        // The consumer took the held result.
        if (out_valid_reg && m_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_value_next  = '0;
                    res_status_next = STAT_DONE;
                    unique case (in_cmd) inside
                        CMD_READ:
                        begin
                            if (pos_ext < cnt_ext)
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = pos_ext[AW-1:0];
                                state_next = ST_RDWAIT;
                            end
                            else
                            begin
                                res_value_next  = '1;
                                res_status_next = STAT_RANGE;
                                state_next      = ST_DONE;
                            end
                        end
                        CMD_HEAD, CMD_TAIL, CMD_AT:
                        begin
                            // The range check comes before the full check.
                            if (ins_ext > cnt_ext)
                            begin
                                res_status_next = STAT_RANGE;
                                state_next      = ST_DONE;
                            end
                            else if (list_full)
                            begin
                                res_status_next = STAT_FULL;
                                state_next      = ST_DONE;
                            end
                            else
                            begin
                                // Entries from count-1 down to the insertion point move up.
                                ins_next   = ins_ext[AW-1:0];
                                val_next   = in_val;
                                del_next   = 1'b0;
                                pend_next  = 1'b0;
                                issue_next = (ins_ext < cnt_ext);
                                ptr_next   = cnt_dec[AW-1:0];
                                last_next  = ins_ext[AW-1:0];
                                state_next = ST_SHIFT;
                            end
                        end
                        CMD_DEL:
                        begin
                            if (pos_ext >= cnt_ext)
                            begin
                                res_status_next = STAT_RANGE;
                                state_next      = ST_DONE;
                            end
                            else
                            begin
                                // Entries above the deleted one move down.
                                del_next   = 1'b1;
                                pend_next  = 1'b0;
                                issue_next = (pos_inc < cnt_ext);
                                ptr_next   = pos_inc[AW-1:0];
                                last_next  = cnt_dec[AW-1:0];
                                state_next = ST_SHIFT;
                            end
                        end
                        default:
                        begin
                            res_status_next = STAT_RANGE;
                            state_next      = ST_DONE;
                        end
                    endcase
                end
            end

            ST_RDWAIT:
            begin
                res_value_next = mem_q;
                state_next     = ST_DONE;
            end

            ST_SHIFT:
            begin
                // Write back the entry read in the previous cycle, one slot over.
                // Writes never land on an address still to be read, so no forwarding is needed.
                if (pend_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = del_reg ? (src_reg - AW'(1)) : (src_reg + AW'(1));
                    mem_wdata = mem_q;
                end

                if (issue_reg)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = ptr_reg;
                    src_next  = ptr_reg;
                    pend_next = 1'b1;
                    if (ptr_reg == last_reg)
                    begin
                        issue_next = 1'b0;
                    end
                    else
                    begin
                        ptr_next = del_reg ? (ptr_reg + AW'(1)) : (ptr_reg - AW'(1));
                    end
                end
                else
                begin
                    pend_next = 1'b0;
                end

                // Shifting is over: place the new value or just shrink the list.
                if (!issue_reg && !pend_reg)
                begin
                    if (del_reg)
                    begin
                        count_next = cnt_dec;
                    end
                    else
                    begin
                        mem_we     = 1'b1;
                        mem_waddr  = ins_reg;
                        mem_wdata  = val_reg;
                        count_next = count_reg + CW'(1);
                    end
                    state_next = ST_DONE;
                end
            end

            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_value_next  = res_value_reg;
                    out_status_next = res_status_reg;
                    out_count_next  = cnt_ext[ECOUNT_W-1:0];
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            issue_reg     <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            issue_reg     <= issue_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        ptr_reg        <= ptr_next;
        last_reg       <= last_next;
        src_reg        <= src_next;
        ins_reg        <= ins_next;
        del_reg        <= del_next;
        val_reg        <= val_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        out_value_reg  <= out_value_next;
        out_status_reg <= out_status_next;
        out_count_reg  <= out_count_next;
    end

    // List memory with a registered read port.
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem_array[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_q <= mem_array[mem_raddr];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W - VALUE_W - STATUS_W - ECOUNT_W){1'b0}},
                       out_count_reg, out_status_reg, out_value_reg};

endmodule

[sv/ile_checker.sv]
// Port-level checker for the indexed list engine and its bind.
`include "indexed_list_engine_macros.svh"

module ile_checker #(
    parameter int LIST_DEPTH = 64
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [ile_pkg::M_TDATA_W-1:0] m_tdata
);
    import ile_pkg::*;

    localparam logic [ECOUNT_W-1:0] FULL_COUNT = ECOUNT_W'(LIST_DEPTH % 128);

    logic [VALUE_W-1:0]  chk_value;
    logic [STATUS_W-1:0] chk_status;
    logic [ECOUNT_W-1:0] chk_count;
    logic                out_stall;
    logic                in_beat;
    logic                out_full;
    logic                range_data;

    assign chk_value  = m_tdata[VALUE_W-1:0];
    assign chk_status = m_tdata[VALUE_W+STATUS_W-1:VALUE_W];
    assign chk_count  = m_tdata[VALUE_W+STATUS_W+ECOUNT_W-1:VALUE_W+STATUS_W];

    assign out_stall  = m_tvalid && !m_tready;
    assign in_beat    = s_tvalid && s_tready;
    assign out_full   = m_tvalid && (chk_status == STAT_FULL);
    assign range_data = m_tvalid && (chk_status == STAT_RANGE) && (chk_value != '0);

    // A stalled result must not change.
    `ILE_ASSERT_NEXT(a_hold_result, out_stall, m_tvalid && $stable(m_tdata), "stalled result moved")

    // Commands are handled one at a time: an accepted beat closes the input side.
    `ILE_ASSERT_NEXT(a_one_at_a_time, in_beat, !s_tready, "command accepted while busy")

    // A full report always shows a list at capacity.
    `ILE_ASSERT_NOW(a_full_count, out_full, chk_count == FULL_COUNT, "full below capacity")

    // A range error carries either no read data or the all-ones marker.
    `ILE_ASSERT_NOW(a_range_value, range_data, chk_value == '1, "bad value on a range error")

endmodule

bind indexed_list_engine ile_checker #(.LIST_DEPTH(LIST_DEPTH)) u_ile_checker (.*);

[bench/testbench.sv]
`timescale 1ns / 100ps
// Self-checking stream testbench for the indexed list engine, with a shadow list predictor.
module testbench;
    import ile_pkg::*;

    localparam int LIST_DEPTH = 64;
    // A command's run time grows with the entries it moves, at most LIST_DEPTH.
    // Add the longest sender gap and the longest receiver stall, then take that
    // many times over before calling the run hung.
    localparam int IDLE_LIMIT = 2000;
    // Quiet time after the last result, so that a stray extra beat is caught.
    localparam int SETTLE_CYCLES = LIST_DEPTH + 8;

    // One expected result beat, split into its fields.
    typedef struct {
        logic signed [VALUE_W-1:0] read_value;
        status_t                   status;
        logic [ECOUNT_W-1:0]       entry_count;
    } list_result_t;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    // command [2:0], position [10:3], value [42:11], zero padding [47:43]
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    // read_value [31:0], status [33:32], entry_count [40:34], zero padding [47:41]
    logic [M_TDATA_W-1:0] m_tdata;

    // Shadow copy of the list contents and its fill level. Entries at and above
    // shadow_count are never read, so their contents do not matter.
    logic signed [VALUE_W-1:0] shadow_list [LIST_DEPTH];
    int                        shadow_count = 0;

    // Results still owed by the block, oldest first.
    list_result_t expected_results [$];

    int error_count = 0;
    int idle_cycles = 0;
    // When set, neither side inserts gaps or stalls.
    bit no_idling = 1'b0;

    indexed_list_engine #(
        .LIST_DEPTH(LIST_DEPTH)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Predictor: applies one command to the shadow list and returns the
    // result the block must produce for it.
    // ------------------------------------------------------------------
    function automatic list_result_t apply_command(cmd_t cmd, int pos,
                                                   logic signed [VALUE_W-1:0] val);
        list_result_t res;
        int           ins_pos;
        res.read_value = '0;
        res.status     = STAT_DONE;
        ins_pos        = -1;
        case (cmd)
            CMD_READ:
            begin
                if (pos < shadow_count)
                begin
                    res.read_value = shadow_list[pos];
                end
                else
                begin
                    // Out-of-range reads return all ones.
                    res.read_value = -1;
                    res.status     = STAT_RANGE;
                end
            end
            CMD_HEAD: ins_pos = 0;
            CMD_TAIL: ins_pos = shadow_count;
            CMD_AT:   ins_pos = pos;
            CMD_DEL:
            begin
                if (pos >= shadow_count)
                begin
                    res.status = STAT_RANGE;
                end
                else
                begin
                    for (int i = pos; i + 1 < shadow_count; i++)
                        shadow_list[i] = shadow_list[i + 1];
                    shadow_count--;
                end
            end
            default: res.status = STAT_RANGE;
        endcase
        if (ins_pos >= 0)
        begin
            // The index check wins over the full check.
            if (ins_pos > shadow_count)
            begin
                res.status = STAT_RANGE;
            end
            else if (shadow_count >= LIST_DEPTH)
            begin
                res.status = STAT_FULL;
            end
            else
            begin
                for (int i = shadow_count; i > ins_pos; i--)
                    shadow_list[i] = shadow_list[i - 1];
                shadow_list[ins_pos] = val;
                shadow_count++;
            end
        end
        res.entry_count = shadow_count[ECOUNT_W-1:0];
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Random helpers for gaps, values and positions.
    // ------------------------------------------------------------------

    // Mostly short stalls, now and then a long one.
    function automatic int stall_length();
        if ($urandom_range(0, 99) < 80)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Gap after an accepted command beat; half the time back to back.
    function automatic int pick_gap();
        if (no_idling || $urandom_range(0, 1) == 0)
            return 0;
        return stall_length();
    endfunction

    // Random value with the extremes mixed in often.
    function automatic logic signed [VALUE_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0:       return 32'sh7FFF_FFFF;
            1:       return 32'sh8000_0000;
            2:       return -1;
            3:       return 0;
            default: return $urandom();
        endcase
    endfunction

    // Positions are mostly legal for the command, with the list edges and
    // arbitrary out-of-range indexes mixed in.
    function automatic int random_position(cmd_t cmd);
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return $urandom_range(0, 255);
        if (r < 15)
            return 0;
        if (r < 20)
            return shadow_count;
        if (cmd == CMD_AT || shadow_count == 0)
            return $urandom_range(0, shadow_count);
        return $urandom_range(0, shadow_count - 1);
    endfunction

    // ------------------------------------------------------------------
    // Command side: drives one beat, waits for the handshake, records the
    // expected result, then optionally leaves a gap. With no gap, tvalid
    // stays high into the next call so back-to-back beats are possible.
    // ------------------------------------------------------------------
    task automatic send_command(cmd_t cmd, int pos, logic signed [VALUE_W-1:0] val);
        logic [S_TDATA_W-1:0] beat;
        list_result_t         res;
        int                   gap;
        beat        = '0;
        beat[2:0]   = cmd;
        beat[10:3]  = pos[POS_W-1:0];
        beat[42:11] = val;
        s_tvalid <= 1'b1;
        s_tdata  <= beat;
        do
            @(posedge clk);
        while (!s_tready);
        res = apply_command(cmd, pos, val);
        expected_results.push_back(res);
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Holds the command side off until every owed result has been taken.
    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
    endtask

    // Random command mix; the weights steer the fill level of the list.
    task automatic run_random_commands(int n, int ins_weight, int del_weight);
        cmd_t cmd;
        int   r;
        repeat (n)
        begin
            r = $urandom_range(0, 99);
            if (r < ins_weight)
            begin
                case ($urandom_range(0, 2))
                    0:       cmd = CMD_HEAD;
                    1:       cmd = CMD_TAIL;
                    default: cmd = CMD_AT;
                endcase
            end
            else if (r < ins_weight + del_weight)
            begin
                cmd = CMD_DEL;
            end
            else
            begin
                cmd = CMD_READ;
            end
            send_command(cmd, random_position(cmd), random_value());
        end
    endtask

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // Commands on an empty list that must be refused: reads, a delete and an out-of-range insert.
    task automatic test_empty_list();
        send_command(CMD_READ, 0, 0);
        send_command(CMD_READ, 255, 0);
        send_command(CMD_DEL, 0, 0);
        send_command(CMD_AT, 1, 32'sh1234_5678);
    endtask

    // Inserts at head, tail, index zero, the append index and the middle,
    // then reads back and deletes at head, tail and middle.
    task automatic test_directed_edits();
        send_command(CMD_HEAD, 0, 32'sh7FFF_FFFF);
        send_command(CMD_TAIL, 0, 32'sh8000_0000);
        send_command(CMD_AT, 0, -1);
        send_command(CMD_AT, 3, 0);
        send_command(CMD_AT, 2, 32'sh5555_5555);
        for (int i = 0; i <= 5; i++)
            send_command(CMD_READ, i, 0);
        send_command(CMD_AT, 255, 32'shAAAA_AAAA);
        send_command(CMD_DEL, 0, 0);
        send_command(CMD_DEL, 3, 0);
        send_command(CMD_DEL, 1, 0);
        send_command(CMD_DEL, 255, 0);
        send_command(CMD_READ, 0, 0);
        send_command(CMD_READ, 1, 0);
    endtask

    // Fills the list to capacity, probes the full cases, then empties it
    // again by deleting at random positions.
    task automatic test_full_list();
        while (shadow_count < LIST_DEPTH)
            send_command(CMD_TAIL, 0, random_value());
        send_command(CMD_HEAD, 0, random_value());
        send_command(CMD_AT, LIST_DEPTH, random_value());
        send_command(CMD_AT, LIST_DEPTH + 1, random_value());
        send_command(CMD_TAIL, 0, random_value());
        send_command(CMD_READ, LIST_DEPTH - 1, 0);
        send_command(CMD_READ, LIST_DEPTH, 0);
        send_command(CMD_DEL, LIST_DEPTH - 1, 0);
        send_command(CMD_AT, LIST_DEPTH - 1, random_value());
        while (shadow_count > 0)
            send_command(CMD_DEL, $urandom_range(0, shadow_count - 1), 0);
    endtask

    // Random traffic: a burst with no idling, then balanced, insert-heavy
    // and delete-heavy phases so the list sweeps between empty and full.
    task automatic test_random_traffic();
        no_idling = 1'b1;
        run_random_commands(80, 35, 30);
        no_idling = 1'b0;
        run_random_commands(150, 35, 30);
        wait_until_drained();
        run_random_commands(120, 60, 15);
        wait_until_drained();
        run_random_commands(120, 20, 50);
    endtask

    // ------------------------------------------------------------------
    // Result side: ready toggles between runs of high and stalls.
    // ------------------------------------------------------------------
    initial
    begin : result_ready_driver
        bit ready_now;
        int run;
        ready_now = 1'b0;
        run       = 0;
        forever
        begin
            @(posedge clk);
            if (run > 0)
            begin
                run--;
            end
            else
            begin
                if (no_idling || !ready_now)
                begin
                    ready_now = 1'b1;
                    run       = $urandom_range(1, 30);
                end
                else
                begin
                    ready_now = 1'b0;
                    run       = stall_length();
                end
                m_tready <= ready_now;
            end
        end
    end

    // Compares every accepted result beat with the oldest expectation.
    always @(posedge clk)
    begin : result_checker
        list_result_t exp;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result beat, expected none, got %h",
                         $time, m_tdata);
                error_count++;
            end
            else
            begin
                exp = expected_results.pop_front();
                if (m_tdata[31:0] !== exp.read_value)
                begin
                    $display("%0t: read_value expected %0d, got %0d",
                             $time, exp.read_value, $signed(m_tdata[31:0]));
                    error_count++;
                end
                if (m_tdata[33:32] !== exp.status)
                begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, exp.status, m_tdata[33:32]);
                    error_count++;
                end
                if (m_tdata[40:34] !== exp.entry_count)
                begin
                    $display("%0t: entry_count expected %0d, got %0d",
                             $time, exp.entry_count, m_tdata[40:34]);
                    error_count++;
                end
            end
        end
    end

    // Watchdog: too long without any beat on either side ends the run.
    always @(posedge clk)
    begin : hang_watchdog
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Test sequence.
    // ------------------------------------------------------------------
    initial
    begin : test_sequence
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_list();
        test_directed_edits();
        wait_until_drained();
        test_full_list();
        wait_until_drained();
        test_random_traffic();
        wait_until_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
